>>> src/sravg_pkg.sv
package sravg_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned STEP_W    = $clog2(SAMPLE_W);
	localparam logic [SAMPLE_W-1:0] MAX_COUNT = 16'd65535;
	localparam logic [SAMPLE_W-1:0] MIN_RESET = 16'hFFFF;

	typedef struct packed {
		logic accept;    // sample item taken this cycle
		logic close;     // accepted item is the last of its run
		logic div_step;  // advance the divider by one quotient bit
		logic out_load;  // move divider result into the output register
	} sravg_cmd_t;

	typedef struct packed {
		logic div_done;  // final quotient bit is produced this cycle
	} sravg_sts_t;

endpackage

>>> src/sravg_ctrl.sv
module sravg_ctrl
	import sravg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       last,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  sravg_sts_t sts,
	output sravg_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;
	logic   load;

	assign in_stall  = (state_q != ST_ACC);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load      = (state_q == ST_LOAD) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept   = accept;
		cmd.close    = accept && last;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (accept && last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/sravg_dp.sv
module sravg_dp
	import sravg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] sample,
	input  sravg_cmd_t          cmd,
	output sravg_sts_t          sts,
	output logic [SAMPLE_W-1:0] average,
	output logic [SAMPLE_W-1:0] largest,
	output logic [SAMPLE_W-1:0] smallest,
	output logic                overrun
);

	// run accumulators
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] count_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic                ovr_q;

	// divider and its snapshot of the closed run
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [SAMPLE_W-1:0] div_q;
	logic                zero_q;
	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] rmax_q;
	logic [SAMPLE_W-1:0] rmin_q;
	logic                rovr_q;

	// output register
	logic [SAMPLE_W-1:0] avg_q;
	logic [SAMPLE_W-1:0] lrg_q;
	logic [SAMPLE_W-1:0] sml_q;
	logic                ovo_q;

	logic                room;
	logic [SUM_W-1:0]    sum_n;
	logic [SAMPLE_W-1:0] count_n;
	logic [SAMPLE_W-1:0] max_n;
	logic [SAMPLE_W-1:0] min_n;
	logic                ovr_n;
	logic [SAMPLE_W:0]   trial;
	logic [SAMPLE_W:0]   diff;
	logic                qbit;

	assign room = (count_q < MAX_COUNT);

	always_comb begin
		sum_n   = sum_q;
		count_n = count_q;
		max_n   = max_q;
		min_n   = min_q;
		ovr_n   = ovr_q;
		if (room) begin
			sum_n   = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
			count_n = count_q + 1'b1;
			if (sample > max_q) begin
				max_n = sample;
			end
			if (sample < min_q) begin
				min_n = sample;
			end
		end else begin
			ovr_n = 1'b1;
		end
	end

	// restoring division, one quotient bit a cycle; the high half of the sum
	// is always below the count, so the quotient fits in SAMPLE_W bits
	assign trial = {rem_q, quo_q[SAMPLE_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = !diff[SAMPLE_W];

	assign sts.div_done = cmd.div_step && (step_q == {STEP_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			max_q   <= '0;
			min_q   <= MIN_RESET;
			ovr_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			if (cmd.close) begin
				sum_q   <= '0;
				count_q <= '0;
				max_q   <= '0;
				min_q   <= MIN_RESET;
				ovr_q   <= 1'b0;
			end else if (cmd.accept) begin
				sum_q   <= sum_n;
				count_q <= count_n;
				max_q   <= max_n;
				min_q   <= min_n;
				ovr_q   <= ovr_n;
			end
			if (cmd.close) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close) begin
			rem_q  <= sum_n[SUM_W-1:SAMPLE_W];
			quo_q  <= sum_n[SAMPLE_W-1:0];
			div_q  <= count_n;
			zero_q <= (count_n == '0);
			rmax_q <= max_n;
			rmin_q <= min_n;
			rovr_q <= ovr_n;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[SAMPLE_W-2:0], qbit};
		end
		if (cmd.out_load) begin
			avg_q <= zero_q ? '0 : quo_q;
			lrg_q <= rmax_q;
			sml_q <= rmin_q;
			ovo_q <= rovr_q;
		end
	end

	assign average  = avg_q;
	assign largest  = lrg_q;
	assign smallest = sml_q;
	assign overrun  = ovo_q;

endmodule

>>> src/sample_run_average_min_max_core.sv
// Running average, maximum and minimum over runs of unsigned 16-bit samples.
// Samples are taken one per cycle while in_stall is low; the item with last
// set closes the run and yields one result item (truncated sum/count average,
// max, min and an overrun flag set when samples beyond 65535 in a run were
// dropped). Closing a run starts the restoring divider, which produces one
// quotient bit a cycle, so in_stall stays high after a last item through the
// 16 divide steps and the load of the output register, and longer if the
// previous result is still stalled there. Non-last items never produce a result.
module sample_run_average_min_max_core
	import sravg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] average,
	output logic [SAMPLE_W-1:0] largest,
	output logic [SAMPLE_W-1:0] smallest,
	output logic                overrun
);

	sravg_cmd_t cmd;
	sravg_sts_t sts;

	sravg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sravg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.cmd      (cmd),
		.sts      (sts),
		.average  (average),
		.largest  (largest),
		.smallest (smallest),
		.overrun  (overrun)
	);

endmodule

>>> src/sravg_chk.sv
module sravg_chk
	import sravg_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                last,
	input logic                out_valid,
	input logic                out_stall,
	input logic [SAMPLE_W-1:0] average,
	input logic [SAMPLE_W-1:0] largest,
	input logic [SAMPLE_W-1:0] smallest,
	input logic                overrun
);

	// a closed run keeps the input side busy while the average is worked out
	a_busy_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input not stalled after run closed");

	// a new result only appears while the input side is held off
	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a divide phase");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(average) && $stable(largest)
			&& $stable(smallest) && $stable(overrun))
		else $error("stalled result item changed");

endmodule

bind sample_run_average_min_max_core sravg_chk u_sravg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.average   (average),
	.largest   (largest),
	.smallest  (smallest),
	.overrun   (overrun)
);
